>>> src/rr2sri_pkg.sv
// shared types, constants and helpers for the scrambled radical inverse block
package rr2sri_pkg;

  localparam int BASE_W = 8;
  localparam int K_W = 4;

  localparam int MAX_BASE_DEF = 256;
  localparam int INDEX_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 32;

  // effective base and its bit length, plus a pulse that starts a table rebuild
  typedef struct packed {
    logic              go;
    logic [BASE_W-1:0] b;
    logic [K_W-1:0]    k;
  } bld_ctl_t;

  function automatic logic [BASE_W-1:0] bit_rev(input logic [BASE_W-1:0] v);
    logic [BASE_W-1:0] res;
    for (int i = 0; i < BASE_W; i++) begin
      res[i] = v[BASE_W-1-i];
    end
    return res;
  endfunction

endpackage

>>> src/rr2sri_csub.sv
// shared compare and subtract unit used by both division loops
module rr2sri_csub #(
  parameter int W = rr2sri_pkg::INDEX_BITS_DEF + rr2sri_pkg::BASE_W + 1
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];

endmodule

>>> src/rr2sri_perm.sv
// permutation table memory and the sweep that rebuilds it for a new base
module rr2sri_perm #(
  parameter int MAX_BASE = rr2sri_pkg::MAX_BASE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rr2sri_pkg::bld_ctl_t            ctl,
  output logic                            building,
  input  logic [$clog2(MAX_BASE)-1:0]     rd_addr,
  output logic [rr2sri_pkg::BASE_W-1:0]   rd_data
);

  localparam int AW = $clog2(MAX_BASE);
  localparam int BW = rr2sri_pkg::BASE_W;

  logic [BW-1:0] mem [MAX_BASE];
  logic [BW-1:0] src;
  logic [BW-1:0] slot;
  logic [BW-1:0] rev;
  logic [BW:0]   m_full;
  logic [BW-1:0] src_last;
  logic          wr;

  // reverse over k bits: full reversal then drop the unused low bits
  assign rev      = rr2sri_pkg::bit_rev(src) >> (rr2sri_pkg::K_W'(BW) - ctl.k);
  assign m_full   = (BW + 1)'(1) << ctl.k;
  assign src_last = BW'(m_full - (BW + 1)'(2));
  assign wr       = building && (slot < ctl.b) && (rev < ctl.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      building <= 1'b0;
    end else if (ctl.go) begin
      building <= 1'b1;
      src      <= '0;
      slot     <= '0;
    end else if (building) begin
      src <= src + 1'b1;
      if (wr) begin
        slot <= slot + 1'b1;
      end
      if (src == src_last) begin
        building <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[slot[AW-1:0]] <= rev;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/rr2_scrambled_radical_inverse.sv
// top level: scrambled radical inverse sequencer
//
// Command interface. An index is taken at a rising edge with start high and
// busy low; busy then stays high until the result is out. The result shows on
// fraction for exactly one cycle with done high; there is no backpressure, the
// receiver must take it in that cycle.
// The index is split into base-b digits by a bit-serial divider, one quotient
// bit per cycle, then the fraction comes from a bit-serial long division, one
// result bit per cycle. Both loops share a single compare/subtract unit.
// Per digit the divider runs over qlen quotient bits (S_DIV), then the table is
// read (S_LOOK) and the digit accumulated (S_ACC); qlen starts at INDEX_BITS
// and each later digit drops floor(log2 b) bits.
// Index zero skips the digit loop. One item is in flight at a time.
// base_we writes the base register (clamped to 2..MAX_BASE-1) and starts a
// table rebuild over k-bit sources (k = bit length of the base), busy meanwhile.
// Reset loads base 2 and runs that rebuild before the first item.
module rr2_scrambled_radical_inverse #(
  parameter int MAX_BASE   = rr2sri_pkg::MAX_BASE_DEF,
  parameter int INDEX_BITS = rr2sri_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = rr2sri_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          base_we,
  input  logic [rr2sri_pkg::BASE_W-1:0] base,
  input  logic                          start,
  input  logic [INDEX_BITS-1:0]         index,
  output logic                          busy,
  output logic                          done,
  output logic [FRAC_BITS-1:0]          fraction
);

  localparam int BW = rr2sri_pkg::BASE_W;
  localparam int KW = rr2sri_pkg::K_W;
  localparam int AW = $clog2(MAX_BASE);
  localparam int DW = INDEX_BITS + AW;
  localparam int RW = DW + 1;
  localparam int IW = $clog2(INDEX_BITS);
  localparam int QW = $clog2(INDEX_BITS + 1);
  localparam int FW = $clog2(FRAC_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FRAC = 3'd4;

  rr2sri_pkg::bld_ctl_t ctl;
  logic                 building;
  logic [BW-1:0]        b_clamp;
  logic [KW-1:0]        k_calc;

  logic [2:0]            state;
  logic [BW-1:0]         ib;
  logic [KW-1:0]         il;
  logic [INDEX_BITS-1:0] q;
  logic [INDEX_BITS-1:0] quot;
  logic [BW-1:0]         rem;
  logic [AW-1:0]         digit;
  logic [IW-1:0]         cnt;
  logic [QW-1:0]         qlen;
  logic [RW-1:0]         r;
  logic [DW-1:0]         den;
  logic [FW-1:0]         fcnt;
  logic [FRAC_BITS-1:0]  frac;
  logic [BW-1:0]         p_rd;

  logic [RW-1:0]         su_a;
  logic [RW-1:0]         su_b;
  logic [RW-1:0]         su_diff;
  logic                  su_ge;

  logic [BW-1:0]         rem_next;
  logic [INDEX_BITS-1:0] quot_next;
  logic [RW-1:0]         r_next;
  logic [FRAC_BITS-1:0]  frac_next;
  logic [DW+BW-1:0]      num_prod;
  logic [DW+BW-1:0]      den_prod;
  logic [DW-1:0]         num_acc;
  logic [QW-1:0]         qlen_next;

  // clamp the written base and find its bit length
  always_comb begin
    b_clamp = base;
    if (base < BW'(2)) begin
      b_clamp = BW'(2);
    end else if ({1'b0, base} > (BW + 1)'(MAX_BASE - 1)) begin
      b_clamp = BW'(MAX_BASE - 1);
    end
    k_calc = '0;
    for (int i = 0; i < BW; i++) begin
      if (b_clamp[i]) begin
        k_calc = KW'(i + 1);
      end
    end
  end

  rr2sri_perm #(
    .MAX_BASE (MAX_BASE)
  ) u_perm (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .building (building),
    .rd_addr  (digit),
    .rd_data  (p_rd)
  );

  // digit division works on a 9-bit partial remainder, the fraction loop on r
  always_comb begin
    if (state == S_DIV) begin
      su_a = RW'({rem, q[cnt]});
      su_b = RW'(ib);
    end else begin
      su_a = {r[DW-1:0], 1'b0};
      su_b = {1'b0, den};
    end
  end

  rr2sri_csub #(
    .W (RW)
  ) u_csub (
    .a    (su_a),
    .b    (su_b),
    .diff (su_diff),
    .ge   (su_ge)
  );

  assign rem_next  = su_ge ? su_diff[BW-1:0] : su_a[BW-1:0];
  assign quot_next = {quot[INDEX_BITS-2:0], su_ge};
  assign r_next    = su_ge ? su_diff : su_a;
  assign frac_next = {frac[FRAC_BITS-2:0], su_ge};
  assign num_prod  = r[DW-1:0] * ib;
  assign den_prod  = den * ib;
  assign num_acc   = num_prod[DW-1:0] + DW'(p_rd);
  // quotient shrinks by at least floor(log2 b) bits per digit
  assign qlen_next = qlen - QW'(il);

  assign busy     = (state != S_IDLE) || building || ctl.go;
  assign fraction = frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      ctl   <= '{go: 1'b1, b: BW'(2), k: KW'(2)};
    end else begin
      done   <= 1'b0;
      ctl.go <= base_we;
      if (base_we) begin
        ctl.b <= b_clamp;
        ctl.k <= k_calc;
      end
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            ib   <= ctl.b;
            il   <= ctl.k - 1'b1;
            q    <= index;
            quot <= '0;
            rem  <= '0;
            cnt  <= IW'(INDEX_BITS - 1);
            qlen <= QW'(INDEX_BITS);
            r    <= '0;
            den  <= DW'(1);
            fcnt <= '0;
            if (index == '0) begin
              state <= S_FRAC;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          quot <= quot_next;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            q     <= quot_next;
            digit <= rem_next[AW-1:0];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          // table read in flight
          state <= S_ACC;
        end
        S_ACC: begin
          r   <= {1'b0, num_acc};
          den <= den_prod[DW-1:0];
          if (q == '0) begin
            fcnt  <= '0;
            state <= S_FRAC;
          end else begin
            qlen  <= qlen_next;
            cnt   <= IW'(qlen_next - 1'b1);
            rem   <= '0;
            quot  <= '0;
            state <= S_DIV;
          end
        end
        S_FRAC: begin
          r    <= r_next;
          frac <= frac_next;
          fcnt <= fcnt + 1'b1;
          if (fcnt == FW'(FRAC_BITS - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a start transfer");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < ib))
    else $error("digit remainder not below the base");

  a_done_from_frac: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_FRAC) && ($past(fcnt) == FW'(FRAC_BITS - 1)))
    else $error("result strobed outside the end of the fraction loop");
`endif

endmodule

>>> tb/sv/tb.sv
// testbench for the rr2 scrambled radical inverse block: directed and random indexes
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BASE    = rr2sri_pkg::MAX_BASE_DEF;
  localparam int INDEX_BITS  = rr2sri_pkg::INDEX_BITS_DEF;
  localparam int FRAC_BITS   = rr2sri_pkg::FRAC_BITS_DEF;
  localparam int BASE_W      = rr2sri_pkg::BASE_W;
  localparam int AW          = $clog2(MAX_BASE);
  // base 2 with a full-width index is the slowest item
  localparam int SETTLE_CYCLES = 700;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [INDEX_BITS-1:0] idx;
    logic [FRAC_BITS-1:0]  frac;
  } fraction_exp_t;

  logic                  clk;
  logic                  rst;
  logic                  base_we;
  logic [BASE_W-1:0]     base;
  logic                  start;
  logic [INDEX_BITS-1:0] index;
  logic                  busy;
  logic                  done;
  logic [FRAC_BITS-1:0]  fraction;

  // predictor state: effective radix and its permutation
  int unsigned   radix;
  logic [7:0]    perm_map [MAX_BASE];

  fraction_exp_t fraction_q [$];
  fraction_exp_t head_exp;
  int            sender_idle_pct = 0;
  int            errors = 0;
  int            items_sent = 0;
  int            results_checked = 0;
  int            base_writes = 0;
  int            radix_min = 255;
  int            radix_max = 0;
  longint        cycle_count = 0;

  rr2_scrambled_radical_inverse dut (
    .clk      (clk),
    .rst      (rst),
    .base_we  (base_we),
    .base     (base),
    .start    (start),
    .index    (index),
    .busy     (busy),
    .done     (done),
    .fraction (fraction)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void rebuild_perm(input logic [BASE_W-1:0] base_raw);
    int unsigned b, m, nbits, t, slot, src, rev, d;
    b = 32'(base_raw);
    if (b < 2) b = 2;
    if (b > MAX_BASE - 1) b = MAX_BASE - 1;
    radix = b;
    m = 0;
    while (m < b) m = (m << 1) | 1;
    nbits = 0;
    for (t = m - 1; t != 0; t = t >> 1) nbits++;
    perm_map = '{default: '0};
    slot = 1;
    for (src = 1; src < m && slot < b; src++) begin
      rev = 0;
      d = src;
      for (int i = 0; i < nbits; i++) begin
        rev = (rev << 1) | (d & 1);
        d = d >> 1;
      end
      // bit-reversed values at or above the radix are dropped
      if (rev < b) begin
        perm_map[AW'(slot)] = rev[7:0];
        slot++;
      end
    end
  endfunction

  function automatic logic [FRAC_BITS-1:0] predict_fraction(input logic [INDEX_BITS-1:0] idx);
    logic [63:0]          q, num, den, r, rdx;
    logic [FRAC_BITS-1:0] frac;
    rdx = 64'(radix);
    q = 64'(idx);
    num = 0;
    den = 1;
    while (q != 0) begin
      num = num * rdx + perm_map[AW'(q % rdx)];
      den = den * rdx;
      q = q / rdx;
    end
    // floor(num * 2^FRAC_BITS / den), num < den
    r = num;
    frac = '0;
    repeat (FRAC_BITS) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= den) begin
        r = r - den;
        frac[0] = 1'b1;
      end
    end
    return frac;
  endfunction

  function automatic logic [INDEX_BITS-1:0] random_index();
    logic [INDEX_BITS-1:0] v;
    int unsigned           len, pick;
    pick = $urandom_range(99);
    v = $urandom;
    if (pick < 5) begin
      v = '0;
    end else if (pick < 15) begin
      v = v;
    end else if (pick < 20) begin
      v = {INDEX_BITS{1'b1}};
    end else begin
      // random lengths from 1 to INDEX_BITS bits vary the digit loop length
      len = $urandom_range(1, INDEX_BITS);
      if (len < INDEX_BITS) v = v & INDEX_BITS'((64'd1 << len) - 1);
    end
    return v;
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return BASE_W'($urandom_range(0, 1));
    if (pick < 25) return BASE_W'($urandom_range(2, 7));
    if (pick < 35) return BASE_W'($urandom_range(250, 255));
    return BASE_W'($urandom_range(2, 255));
  endfunction

  // one index transfer, with an optional gap before it
  task automatic send_index(input logic [INDEX_BITS-1:0] value);
    int            gap;
    fraction_exp_t e;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 40);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    index = value;
    do @(posedge clk); while (busy);
    e.idx = value;
    e.frac = predict_fraction(value);
    fraction_q.push_back(e);
    items_sent++;
  endtask

  // stop sending and wait until every expected fraction has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    drain();
    @(negedge clk);
    base = value;
    base_we = 1'b1;
    @(posedge clk);
    rebuild_perm(value);
    base_writes++;
    if (radix < radix_min) radix_min = radix;
    if (radix > radix_max) radix_max = radix;
    @(negedge clk);
    base_we = 1'b0;
  endtask

  // table built at reset for base 2, binary digits
  task automatic test_reset_base();
    logic [INDEX_BITS-1:0] vals [8];
    vals = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000,
             32'hAAAA_AAAA, 32'h5555_5555};
    rebuild_perm(8'd2);
    radix_min = 2;
    radix_max = 2;
    foreach (vals[i]) send_index(vals[i]);
  endtask

  task automatic test_base_extremes();
    write_base(8'd255);
    send_index(32'h0);
    send_index(32'h1);
    send_index(32'd254);
    send_index(32'd255);
    send_index(32'hFFFF_FFFF);
    write_base(8'd3);
    send_index(32'd1);
    send_index(32'd2);
    send_index(32'hFFFF_FFFF);
  endtask

  // bases 0 and 1 saturate to 2; 128 is exactly a power of two
  task automatic test_base_saturation();
    write_base(8'd0);
    send_index(32'd6);
    send_index(32'hFFFF_FFFF);
    write_base(8'd1);
    send_index(32'd9);
    write_base(8'd128);
    send_index(32'd127);
    send_index(32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int n_items,
                                     input logic [BASE_W-1:0] first_base);
    int sent, seg_len;
    sender_idle_pct = idle_pct;
    sent = 0;
    write_base(first_base);
    while (sent < n_items) begin
      seg_len = $urandom_range(40, 80);
      for (int i = 0; i < seg_len && sent < n_items; i++) begin
        // occasional full stop with results still outstanding
        if ($urandom_range(99) < 3) drain();
        send_index(random_index());
        sent++;
      end
      if (sent < n_items) write_base(random_base());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (fraction_q.size() == 0) begin
        $display("%0t: unexpected result, fraction %h", $time, fraction);
        errors++;
      end else begin
        head_exp = fraction_q.pop_front();
        results_checked++;
        if (fraction !== head_exp.frac) begin
          $display("%0t: index %h: expected fraction %h, got %h",
                   $time, head_exp.idx, head_exp.frac, fraction);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, fraction_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    base_we = 1'b0;
    base = 8'd2;
    index = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_reset_base();
    test_base_extremes();
    test_base_saturation();
    test_random_traffic(13, 370, 8'd2);
    test_random_traffic(50, 370, 8'd255);
    test_random_traffic(0, 370, random_base());

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d index transfers, %0d fractions checked", items_sent,
             results_checked);
    $display("over %0d base writes, effective radix %0d to %0d, saturated bases included",
             base_writes, radix_min, radix_max);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
